// ===== sv/rhk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rhk_pkg;

    localparam logic [14:0] HUE_60 = 15'd3840;
    localparam logic [14:0] HUE_FULL = 15'd23040;

    typedef enum logic [2:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_HUE_HIGH = 3'd1,
        CFG_SAT_LOW  = 3'd2,
        CFG_SAT_HIGH = 3'd3,
        CFG_VAL_LOW  = 3'd4,
        CFG_VAL_HIGH = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic            valid;
        logic [19:0]     hrem;     // hue partial remainder
        logic [19:0]     hnum;     // hue dividend, 3840*255 fits in 20 bits
        logic [11:0]     hquo;
        logic [7:0]      hden;     // delta
        logic [15:0]     srem;
        logic [15:0]     snum;
        logic [7:0]      squo;
        logic [7:0]      sden;     // max
        logic            neg;
        sector_t         sector;
        logic            grey;
        logic [7:0]      value;
    } cell_t;

endpackage
`default_nettype wire

// ===== sv/rhk_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one restoring divide step for both hue and saturation quotients
module rhk_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire rhk_pkg::cell_t d_in,
    output rhk_pkg::cell_t      d_out
);

    rhk_pkg::cell_t d_reg;
    rhk_pkg::cell_t d_next;
    logic [20:0] htry;
    logic [16:0] stry;
    logic [20:0] hsh;
    logic [16:0] ssh;

    always_comb begin
        d_next = d_in;
        hsh = {d_in.hrem, d_in.hnum[19]};
        htry = hsh - {13'd0, d_in.hden};
        d_next.hnum = {d_in.hnum[18:0], 1'b0};
        if (!htry[20]) begin
            d_next.hrem = htry[19:0];
            d_next.hquo = {d_in.hquo[10:0], 1'b1};
        end else begin
            d_next.hrem = hsh[19:0];
            d_next.hquo = {d_in.hquo[10:0], 1'b0};
        end
        ssh = {d_in.srem, d_in.snum[15]};
        stry = ssh - {9'd0, d_in.sden};
        d_next.snum = {d_in.snum[14:0], 1'b0};
        if (!stry[16]) begin
            d_next.srem = stry[15:0];
            d_next.squo = {d_in.squo[6:0], 1'b1};
        end else begin
            d_next.srem = ssh[15:0];
            d_next.squo = {d_in.squo[6:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
`default_nettype wire

// ===== sv/rgb_to_hsv_range_key_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// RGB to HSV with range key. One pixel per clock in and out, with the whole
// pipe advancing only when the output register is free or being taken. Stages:
// a front register for max/min and sector selection, a chain of 20 divider
// cells (one quotient bit each for the hue ratio 3840*num/delta, the last 16
// also for 255*delta/max), and an output register for hue offset and key compare.
module rgb_to_hsv_range_key_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [14:0]      m_hue,
    output logic [7:0]       m_saturation,
    output logic [7:0]       m_value,
    output logic             m_in_key,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    localparam int unsigned NCELL = 20;

    logic [14:0] hue_low_reg, hue_high_reg;
    logic [7:0]  sat_low_reg, sat_high_reg, val_low_reg, val_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_reg  <= 15'd0;
            hue_high_reg <= 15'd23039;
            sat_low_reg  <= 8'd0;
            sat_high_reg <= 8'd255;
            val_low_reg  <= 8'd0;
            val_high_reg <= 8'd255;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rhk_pkg::CFG_HUE_LOW:  hue_low_reg  <= cfg_data;
                rhk_pkg::CFG_HUE_HIGH: hue_high_reg <= cfg_data;
                rhk_pkg::CFG_SAT_LOW:  sat_low_reg  <= cfg_data[7:0];
                rhk_pkg::CFG_SAT_HIGH: sat_high_reg <= cfg_data[7:0];
                rhk_pkg::CFG_VAL_LOW:  val_low_reg  <= cfg_data[7:0];
                rhk_pkg::CFG_VAL_HIGH: val_high_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    // front stage
    logic [7:0] mx, mn, dl, a, b;
    rhk_pkg::sector_t sec;
    rhk_pkg::cell_t front_reg, front_next;
    logic [7:0] nmag;

    always_comb begin
        mx = s_red;
        if (s_green > mx) mx = s_green;
        if (s_blue > mx) mx = s_blue;
        mn = s_red;
        if (s_green < mn) mn = s_green;
        if (s_blue < mn) mn = s_blue;
        dl = mx - mn;
        if (s_red == mx) begin
            sec = rhk_pkg::SEC_RED;   a = s_green; b = s_blue;
        end else if (s_green == mx) begin
            sec = rhk_pkg::SEC_GREEN; a = s_blue;  b = s_red;
        end else begin
            sec = rhk_pkg::SEC_BLUE;  a = s_red;   b = s_green;
        end
        nmag = (a >= b) ? a - b : b - a;
        front_next = '0;
        front_next.valid = s_valid;
        front_next.hnum = 20'(nmag) * 20'(rhk_pkg::HUE_60);
        front_next.hden = dl;
        front_next.sden = mx;
        front_next.neg = (a < b);
        front_next.sector = sec;
        front_next.grey = (dl == 8'd0);
        front_next.value = mx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (adv) begin
            front_reg <= front_next;
        end
    end

    // saturation cells start 4 stages after hue cells; the early cells only
    // carry delta and max along, and the saturation dividend is loaded at cell 4
    rhk_pkg::cell_t chain [0:NCELL];
    rhk_pkg::cell_t link  [0:NCELL-1];

    assign chain[0] = front_reg;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        // saturation divider uses 16 dividend bits, so it joins at cell 4
        always_comb begin
            link[i] = chain[i];
            if (i < NCELL - 16) begin
                link[i].srem = '0;
            end else if (i == NCELL - 16) begin
                link[i].srem = '0;
                link[i].snum = {chain[i].hden, 8'd0} - {8'd0, chain[i].hden};
            end
        end
        rhk_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (adv),
            .d_in   (link[i]),
            .d_out  (chain[i+1])
        );
    end

    // output stage
    rhk_pkg::cell_t last;
    logic [15:0] q;
    logic [15:0] hsum;
    logic [14:0] hue_next;
    logic [7:0]  sat_next;
    logic [14:0] base;
    logic [14:0] hue_reg;
    logic [7:0]  sat_reg, val_reg;
    logic        key_reg, key_next;

    assign last = chain[NCELL];

    always_comb begin
        unique case (last.sector)
            rhk_pkg::SEC_RED:   base = 15'd0;
            rhk_pkg::SEC_GREEN: base = 15'd7680;
            default:            base = 15'd15360;
        endcase
        q = {4'd0, last.hquo} + {15'd0, last.neg && (last.hrem != 20'd0)};
        if (last.neg) begin
            hsum = {1'b0, base} - q;
            if (hsum[15]) hsum = hsum + {1'b0, rhk_pkg::HUE_FULL};
        end else begin
            hsum = {1'b0, base} + q;
        end
        hue_next = last.grey ? 15'd0 : hsum[14:0];
        sat_next = (last.value == 8'd0) ? 8'd0 : last.squo;
        key_next = hue_next >= hue_low_reg && hue_next <= hue_high_reg &&
                   sat_next >= sat_low_reg && sat_next <= sat_high_reg &&
                   last.value >= val_low_reg && last.value <= val_high_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= last.value;
            key_reg <= key_next;
        end
    end

    assign m_hue = hue_reg;
    assign m_saturation = sat_reg;
    assign m_value = val_reg;
    assign m_in_key = key_reg;

`ifndef NO_ASSERTIONS
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue < rhk_pkg::HUE_FULL) else $error("hue out of range");
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_value == 8'd0) |-> (m_hue == 15'd0 && m_saturation == 8'd0))
        else $error("black pixel with hue or saturation");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hue) && $stable(m_in_key)))
        else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

// ===== test/rgb_to_hsv_range_key_unit_test.sv =====
`timescale 1ns / 1ps
module rgb_to_hsv_range_key_unit_test;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  value;
        logic        in_key;
    } hsv_t;

    localparam int STALL_LIMIT = 2000;
    localparam int PIPE_DEPTH = 22;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_red = '0;
    logic [7:0]  s_green = '0;
    logic [7:0]  s_blue = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [14:0] m_hue;
    logic [7:0]  m_saturation;
    logic [7:0]  m_value;
    logic        m_in_key;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;

    // predictor copy of the range registers
    logic [14:0] key_hue_lo, key_hue_hi;
    logic [7:0]  key_sat_lo, key_sat_hi, key_val_lo, key_val_hi;

    hsv_t pending_hsv[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   error_count = 0;
    int   pixels_sent = 0;
    int   pixels_checked = 0;
    int   keyed_count = 0;
    int   idle_cycles = 0;

    rgb_to_hsv_range_key_unit dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic hsv_t predict_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int mx, mn, d, h, num, mag, q;
        hsv_t res;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        h = 0;
        res.saturation = (mx == 0) ? 8'd0 : 8'((255 * d) / mx);
        if (mx != 0 && d != 0) begin
            if (r == mx) begin
                num = int'(g) - int'(b);
                h = 0;
            end else if (g == mx) begin
                num = int'(b) - int'(r);
                h = 7680;
            end else begin
                num = int'(r) - int'(g);
                h = 15360;
            end
            mag = (num < 0 ? -num : num) * 3840;
            // floor toward minus infinity
            q = (num >= 0) ? mag / d : -((mag + d - 1) / d);
            h = h + q;
            if (h < 0) h = h + 23040;
        end
        res.hue = 15'(h);
        res.value = 8'(mx);
        res.in_key = (res.hue >= key_hue_lo) && (res.hue <= key_hue_hi)
            && (res.saturation >= key_sat_lo) && (res.saturation <= key_sat_hi)
            && (res.value >= key_val_lo) && (res.value <= key_val_hi);
        return res;
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_hsv = {pending_hsv, predict_hsv(r, g, b)};
        pixels_sent++;
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_range(rhk_pkg::cfg_idx_t idx, logic [14:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            rhk_pkg::CFG_HUE_LOW:  key_hue_lo = data;
            rhk_pkg::CFG_HUE_HIGH: key_hue_hi = data;
            rhk_pkg::CFG_SAT_LOW:  key_sat_lo = data[7:0];
            rhk_pkg::CFG_SAT_HIGH: key_sat_hi = data[7:0];
            rhk_pkg::CFG_VAL_LOW:  key_val_lo = data[7:0];
            default:               key_val_hi = data[7:0];
        endcase
    endtask

    task automatic set_ranges(logic [14:0] hl, logic [14:0] hh, logic [7:0] sl,
                              logic [7:0] sh, logic [7:0] vl, logic [7:0] vh);
        drain_pipe();
        write_range(rhk_pkg::CFG_HUE_LOW, hl);
        write_range(rhk_pkg::CFG_HUE_HIGH, hh);
        write_range(rhk_pkg::CFG_SAT_LOW, {7'd0, sl});
        write_range(rhk_pkg::CFG_SAT_HIGH, {7'd0, sh});
        write_range(rhk_pkg::CFG_VAL_LOW, {7'd0, vl});
        write_range(rhk_pkg::CFG_VAL_HIGH, {7'd0, vh});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_special_pixels();
        send_pixel(8'd0, 8'd0, 8'd0);       // black
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128); // grey
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);     // just below full circle
        send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie
        send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie
        send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd13, 8'd77);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd254, 8'd1, 8'd127);
    endtask

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                send_pixel(8'($urandom_range(3)), 8'($urandom_range(3)),
                           8'($urandom_range(3)));
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_key_ranges();
        // narrow window
        set_ranges(15'd3000, 15'd12000, 8'd50, 8'd200, 8'd40, 8'd220);
        random_burst(60);
        // inverted ranges accept nothing
        set_ranges(15'd9000, 15'd100, 8'd255, 8'd0, 8'd255, 8'd0);
        random_burst(30);
        // hue bounds past full circle, max register values
        set_ranges(15'h7fff, 15'h7fff, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        random_burst(20);
        set_ranges(15'd0, 15'h7fff, 8'd0, 8'd255, 8'd0, 8'd255);
        random_burst(40);
        set_ranges(15'd23039, 15'd23039, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        random_burst(20);
    endtask

    task automatic test_backpressure();
        set_ranges(15'd0, 15'd23039, 8'd0, 8'd255, 8'd0, 8'd255);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_burst(200);
        send_idle_pct = 76; recv_stall_pct = 0;
        random_burst(150);
        send_idle_pct = 0; recv_stall_pct = 76;
        random_burst(150);
        // pause until the pipe has emptied, then carry on
        s_valid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge aclk);
        send_idle_pct = 13; recv_stall_pct = 13;
        random_burst(150);
        set_ranges(15'($urandom_range(23039)), 15'($urandom_range(23039)),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_idle_pct = 0; recv_stall_pct = 0;
        random_burst(100);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        hsv_t exp_hsv;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hsv.size() == 0) begin
                $display("%0t: unexpected result hue %0d sat %0d val %0d key %0b",
                         $time, m_hue, m_saturation, m_value, m_in_key);
                error_count++;
            end else begin
                exp_hsv = pending_hsv.pop_front();
                pixels_checked++;
                if (m_in_key) keyed_count++;
                if (m_hue !== exp_hsv.hue || m_saturation !== exp_hsv.saturation
                    || m_value !== exp_hsv.value || m_in_key !== exp_hsv.in_key) begin
                    $display("%0t: mismatch expected h %0d s %0d v %0d k %0b, got h %0d s %0d v %0d k %0b",
                             $time, exp_hsv.hue, exp_hsv.saturation, exp_hsv.value,
                             exp_hsv.in_key, m_hue, m_saturation, m_value, m_in_key);
                    error_count++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("rgb_to_hsv_range_key_unit_test failed");
            $finish;
        end
    end

    initial begin
        key_hue_lo = 15'd0; key_hue_hi = 15'd23039;
        key_sat_lo = 8'd0; key_sat_hi = 8'd255;
        key_val_lo = 8'd0; key_val_hi = 8'd255;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_pixels();
        test_key_ranges();
        test_backpressure();
        drain_pipe();
        $display("covered %0d pixels (%0d keyed) over several range settings,",
                 pixels_checked, keyed_count);
        $display("with and without sender gaps and receiver stalls");
        if (error_count == 0)
            $display("rgb_to_hsv_range_key_unit_test passed");
        else
            $display("rgb_to_hsv_range_key_unit_test failed");
        $finish;
    end
endmodule
